/* design/ffba_pkg.sv */
// Shared types and constants for the first-fit block allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int HDR_BYTES   = 16;
    localparam int SPLIT_EXTRA = 16;

    // Result codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_NOMEM   = 3'd2;
    localparam logic [2:0] ST_DOUBLE  = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    // Request modes.
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Block tags.
    localparam logic [1:0] TAG_NEVER = 2'd0;
    localparam logic [1:0] TAG_ALLOC = 2'd1;
    localparam logic [1:0] TAG_FREED = 2'd2;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_INIT      = 4'd1;
    localparam logic [3:0] OP_CAPTURE   = 4'd2;
    localparam logic [3:0] OP_FINISH    = 4'd3;
    localparam logic [3:0] OP_READ      = 4'd4;
    localparam logic [3:0] OP_NEXT      = 4'd5;
    localparam logic [3:0] OP_GRANT     = 4'd6;
    localparam logic [3:0] OP_SHIFT_WR  = 4'd7;
    localparam logic [3:0] OP_SHIFT_END = 4'd8;
    localparam logic [3:0] OP_QUERY     = 4'd9;
    localparam logic [3:0] OP_RELEASE   = 4'd10;
    localparam logic [3:0] OP_MLOAD     = 4'd11;
    localparam logic [3:0] OP_MSTEP     = 4'd12;
    localparam logic [3:0] OP_MEND      = 4'd13;
    localparam logic [3:0] OP_EMIT      = 4'd14;

    // One block table entry.
    typedef struct packed {
        logic [15:0] start;
        logic [15:0] size;
        logic        free;
        logic [1:0]  tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Controller to datapath.
    typedef struct packed {
        logic [3:0] op;
        logic [2:0] code;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_alloc;
        logic is_fq;
        logic is_query;
        logic zero_req;
        logic is_null;
        logic idx_end;
        logic fit;
        logic split;
        logic match;
        logic tag_freed;
        logic tag_alloc;
        logic out_free;
    } t_sts;

endpackage

/* design/ffba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffba_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* design/ffba_ctrl.sv */
// Controller state machine of the allocator: sequences table scans.
// Depends on ffba_pkg for the command and status structs.
`timescale 1ns / 1ps

module ffba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ffba_pkg::t_sts i_sts,
    output ffba_pkg::t_cmd o_cmd
);
    import ffba_pkg::*;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_A_RD   = 4'd3;
    localparam logic [3:0] S_A_CHK  = 4'd4;
    localparam logic [3:0] S_SH_RD  = 4'd5;
    localparam logic [3:0] S_SH_WR  = 4'd6;
    localparam logic [3:0] S_F_RD   = 4'd7;
    localparam logic [3:0] S_F_CHK  = 4'd8;
    localparam logic [3:0] S_M_RD0  = 4'd9;
    localparam logic [3:0] S_M_LD   = 4'd10;
    localparam logic [3:0] S_M_RD   = 4'd11;
    localparam logic [3:0] S_M_CHK  = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NOP;
        o_cmd.code = ST_OK;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.op = OP_INIT;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_alloc) begin
                    if (i_sts.zero_req) begin
                        o_cmd.op   = OP_FINISH;
                        o_cmd.code = ST_ZERO;
                        n_state    = S_DONE;
                    end else begin
                        n_state = S_A_RD;
                    end
                end else if (i_sts.is_fq) begin
                    if (i_sts.is_null) begin
                        o_cmd.op   = OP_FINISH;
                        o_cmd.code = ST_ZERO;
                        n_state    = S_DONE;
                    end else begin
                        n_state = S_F_RD;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_A_RD: begin
                if (i_sts.idx_end) begin
                    o_cmd.op   = OP_FINISH;
                    o_cmd.code = ST_NOMEM;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.op = OP_READ;
                    n_state  = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (i_sts.fit) begin
                    o_cmd.op = OP_GRANT;
                    n_state  = i_sts.split ? S_SH_RD : S_DONE;
                end else begin
                    o_cmd.op = OP_NEXT;
                    n_state  = S_A_RD;
                end
            end
            S_SH_RD: begin
                if (i_sts.idx_end) begin
                    o_cmd.op = OP_SHIFT_END;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_READ;
                    n_state  = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.op = OP_SHIFT_WR;
                n_state  = S_SH_RD;
            end
            S_F_RD: begin
                if (i_sts.idx_end) begin
                    o_cmd.op   = OP_FINISH;
                    o_cmd.code = ST_INVALID;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.op = OP_READ;
                    n_state  = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (!i_sts.match) begin
                    o_cmd.op = OP_NEXT;
                    n_state  = S_F_RD;
                end else if (i_sts.tag_freed) begin
                    o_cmd.op   = OP_FINISH;
                    o_cmd.code = ST_DOUBLE;
                    n_state    = S_DONE;
                end else if (!i_sts.tag_alloc) begin
                    o_cmd.op   = OP_FINISH;
                    o_cmd.code = ST_INVALID;
                    n_state    = S_DONE;
                end else if (i_sts.is_query) begin
                    o_cmd.op = OP_QUERY;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_RELEASE;
                    n_state  = S_M_RD0;
                end
            end
            S_M_RD0: begin
                o_cmd.op = OP_READ;
                n_state  = S_M_LD;
            end
            S_M_LD: begin
                o_cmd.op = OP_MLOAD;
                n_state  = S_M_RD;
            end
            S_M_RD: begin
                if (i_sts.idx_end) begin
                    o_cmd.op = OP_MEND;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_READ;
                    n_state  = S_M_CHK;
                end
            end
            S_M_CHK: begin
                o_cmd.op = OP_MSTEP;
                n_state  = S_M_RD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/ffba_dpath.sv */
// Datapath of the allocator: block table RAM, scan pointers and result registers.
// Depends on ffba_pkg and ffba_ram.
`timescale 1ns / 1ps

module ffba_dpath #(
    parameter int HEAP_BYTES = 65536,
    parameter int MAX_BLOCKS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ffba_pkg::t_cmd i_cmd,
    output ffba_pkg::t_sts o_sts,
    input  logic [1:0]     i_mode,
    input  logic [15:0]    i_request_size,
    input  logic [15:0]    i_payload_offset,
    input  logic           i_null_pointer,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [2:0]     o_status,
    output logic [15:0]    o_granted_offset,
    output logic [15:0]    o_block_bytes,
    output logic [31:0]    o_used_bytes
);
    import ffba_pkg::*;

    localparam int AW    = $clog2(MAX_BLOCKS);
    localparam int CW    = $clog2(MAX_BLOCKS + 1);
    localparam int MAXB  = MAX_BLOCKS;

    logic [1:0]    r_mode;
    logic [16:0]   r_req;
    logic [15:0]   r_ptr;
    logic          r_null;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_wp;
    logic [CW-1:0] r_k;
    logic [31:0]   r_used;
    t_entry        r_acc;
    t_entry        r_carry;
    logic [2:0]    r_status;
    logic [15:0]   r_granted;
    logic [15:0]   r_bytes;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic          ram_re;
    t_entry        rd;
    t_entry        rd_mod;
    logic          merge_ok;
    logic [16:0]   rd_payload;
    logic [16:0]   acc_end;
    logic [16:0]   req_rounded;

    ffba_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_BLOCKS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(rd)
    );

    // Entry as seen by the merge pass: the block being released reads as freed.
    always_comb begin
        rd_mod = rd;
        if (r_idx == r_k) begin
            rd_mod.free = 1'b1;
            rd_mod.tag  = TAG_FREED;
        end
    end

    assign rd_payload  = {1'b0, rd.start} + 17'(HDR_BYTES);
    assign acc_end     = {1'b0, r_acc.start} + 17'(HDR_BYTES) + {1'b0, r_acc.size};
    assign merge_ok    = r_acc.free && rd_mod.free && (acc_end == {1'b0, rd_mod.start});
    assign req_rounded = ({1'b0, i_request_size} + 17'd7) & ~17'd7;

    // Status toward the controller.
    always_comb begin
        o_sts.is_alloc  = (r_mode == MODE_ALLOC);
        o_sts.is_fq     = (r_mode == MODE_FREE) || (r_mode == MODE_QUERY);
        o_sts.is_query  = (r_mode == MODE_QUERY);
        o_sts.zero_req  = (r_req == 17'd0);
        o_sts.is_null   = r_null;
        o_sts.idx_end   = (r_idx == r_count);
        o_sts.fit       = rd.free && ({1'b0, rd.size} >= r_req);
        o_sts.split     = ({2'b0, rd.size} >= {1'b0, r_req} + 18'(HDR_BYTES + SPLIT_EXTRA))
                          && (r_count < CW'(MAXB));
        o_sts.match     = (rd_payload == {1'b0, r_ptr});
        o_sts.tag_freed = (rd.tag == TAG_FREED);
        o_sts.tag_alloc = (rd.tag == TAG_ALLOC);
        o_sts.out_free  = !o_out_valid || i_out_ready;
    end

    // Table write port.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = r_carry;
        ram_re    = (i_cmd.op == OP_READ);
        case (i_cmd.op)
            OP_INIT: begin
                ram_we          = 1'b1;
                ram_waddr       = '0;
                ram_wdata.start = '0;
                ram_wdata.size  = 16'(HEAP_BYTES - HDR_BYTES);
                ram_wdata.free  = 1'b1;
                ram_wdata.tag   = TAG_NEVER;
            end
            OP_GRANT: begin
                ram_we         = 1'b1;
                ram_wdata      = rd;
                ram_wdata.size = o_sts.split ? r_req[15:0] : rd.size;
                ram_wdata.free = 1'b0;
                ram_wdata.tag  = TAG_ALLOC;
            end
            OP_SHIFT_WR, OP_SHIFT_END: begin
                ram_we = 1'b1;
            end
            OP_MSTEP: begin
                ram_we    = !merge_ok;
                ram_waddr = r_wp[AW-1:0];
                ram_wdata = r_acc;
            end
            OP_MEND: begin
                ram_we    = 1'b1;
                ram_waddr = r_wp[AW-1:0];
                ram_wdata = r_acc;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CW'(1);
            r_used      <= '0;
            r_idx       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            // A new result beat is only emitted once the output register is free.
            if (i_cmd.op == OP_EMIT) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_INIT: begin
                    r_count <= CW'(1);
                end
                OP_CAPTURE: begin
                    r_idx <= '0;
                end
                OP_NEXT, OP_SHIFT_WR: begin
                    r_idx <= r_idx + CW'(1);
                end
                OP_GRANT: begin
                    r_idx  <= r_idx + CW'(1);
                    r_used <= r_used + 32'(r_req) + 32'(HDR_BYTES);
                end
                OP_SHIFT_END: begin
                    r_count <= r_count + CW'(1);
                end
                OP_RELEASE: begin
                    r_idx  <= '0;
                    r_used <= r_used - 32'(rd.size) - 32'(HDR_BYTES);
                end
                OP_MLOAD: begin
                    r_idx <= CW'(1);
                end
                OP_MSTEP: begin
                    r_idx <= r_idx + CW'(1);
                end
                OP_MEND: begin
                    r_count <= r_wp + CW'(1);
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_mode    <= i_mode;
                r_req     <= req_rounded;
                r_ptr     <= i_payload_offset;
                r_null    <= i_null_pointer;
                r_status  <= ST_OK;
                r_granted <= '0;
                r_bytes   <= '0;
            end
            OP_FINISH: begin
                r_status <= i_cmd.code;
            end
            OP_GRANT: begin
                r_granted     <= rd_payload[15:0];
                r_carry.start <= 16'(rd_payload + r_req);
                r_carry.size  <= 16'({1'b0, rd.size} - r_req - 17'(HDR_BYTES));
                r_carry.free  <= 1'b1;
                r_carry.tag   <= TAG_NEVER;
            end
            OP_SHIFT_WR: begin
                r_carry <= rd;
            end
            OP_QUERY: begin
                r_bytes <= rd.size;
            end
            OP_RELEASE: begin
                r_k <= r_idx;
            end
            OP_MLOAD: begin
                r_acc <= rd_mod;
                r_wp  <= '0;
            end
            OP_MSTEP: begin
                if (merge_ok) begin
                    r_acc.size <= r_acc.size + 16'(HDR_BYTES) + rd_mod.size;
                end else begin
                    r_acc <= rd_mod;
                    r_wp  <= r_wp + CW'(1);
                end
            end
            OP_EMIT: begin
                o_status         <= r_status;
                o_granted_offset <= r_granted;
                o_block_bytes    <= r_bytes;
                o_used_bytes     <= r_used;
            end
            default: begin
                r_mode <= r_mode;
            end
        endcase
    end

endmodule

/* design/first_fit_block_allocator_core.sv */
// Top level of the first-fit block allocator.
// Depends on ffba_pkg, ffba_ctrl and ffba_dpath.
`timescale 1ns / 1ps

// First-fit heap allocator with coalescing over a HEAP_BYTES region, holding an
// address-ordered table of up to MAX_BLOCKS blocks in one RAM. One request is
// handled at a time; each produces exactly one result beat. The registered read
// of the table RAM sets the pace: each visited entry is first read, then used.
// Allocate scans for the first fitting entry and takes it, then shifts the rest
// of the table up by one entry when the block is split. Free and size query scan
// for the block; free then adds a merge pass over the table. A scan may also run
// to the end of the table and find nothing. Each request also passes through
// capture and decode before its scan and an emit step after it, which waits while
// the receiver holds off the previous beat. After reset the block writes the
// initial table entry before it accepts requests.
module first_fit_block_allocator_core #(
    parameter int HEAP_BYTES = 65536,
    parameter int MAX_BLOCKS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_request_size,
    input  logic [15:0] i_payload_offset,
    input  logic        i_null_pointer,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_granted_offset,
    output logic [15:0] o_block_bytes,
    output logic [31:0] o_used_bytes
);
    import ffba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    ffba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // Table, pointers and result registers.
    ffba_dpath #(
        .HEAP_BYTES(HEAP_BYTES),
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_mode),
        .i_request_size  (i_request_size),
        .i_payload_offset(i_payload_offset),
        .i_null_pointer  (i_null_pointer),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_granted_offset(o_granted_offset),
        .o_block_bytes   (o_block_bytes),
        .o_used_bytes    (o_used_bytes)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for first_fit_block_allocator_core.
// Depends on ffba_pkg and the allocator RTL. It predicts every result beat
// with its own model of the block table and compares it field by field.
`timescale 1ns / 1ps

module tb_top;
    import ffba_pkg::*;

    localparam int HEAP     = 65536;
    localparam int NBLK     = 64;
    localparam int LIMIT    = 3000000;
    localparam int DRAIN    = 600;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_mode = MODE_ALLOC;
    logic [15:0] i_request_size = '0;
    logic [15:0] i_payload_offset = '0;
    logic        i_null_pointer = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_granted_offset;
    logic [15:0] o_block_bytes;
    logic [31:0] o_used_bytes;

    int errors = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] granted;
        logic [15:0] bytes;
        logic [31:0] used;
    } t_result;

    // One line per mismatch, and the count behind the final verdict.
    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("ERROR at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    endtask

    // Block table predictor and the queue of result beats still owed.
    class alloc_scoreboard;
        int unsigned blk_start[NBLK];
        int unsigned blk_size[NBLK];
        bit          blk_free[NBLK];
        logic [1:0]  blk_tag[NBLK];
        int unsigned blk_cnt;
        logic [31:0] used;
        t_result     owed[$];

        function void clear();
            for (int i = 0; i < NBLK; i++) begin
                blk_start[i] = 0;
                blk_size[i] = 0;
                blk_free[i] = 0;
                blk_tag[i] = TAG_NEVER;
            end
            blk_size[0] = HEAP - HDR_BYTES;
            blk_free[0] = 1;
            blk_cnt = 1;
            used = '0;
            owed.delete();
        endfunction

        function void copy_entry(int unsigned dst, int unsigned src);
            blk_start[dst] = blk_start[src];
            blk_size[dst] = blk_size[src];
            blk_free[dst] = blk_free[src];
            blk_tag[dst] = blk_tag[src];
        endfunction

        // Predicts the result of one accepted request and updates the table.
        function void note_request(logic [1:0] mode, logic [15:0] req, logic [15:0] ptr,
                                   logic is_null);
            t_result     r;
            int unsigned rq;
            int          k;
            int unsigned i;
            r = '0;
            r.status = ST_OK;
            if (mode == MODE_ALLOC) begin
                if (req == 0) begin
                    r.status = ST_ZERO;
                end else begin
                    rq = (int'(req) + 7) & ~32'd7;
                    r.status = ST_NOMEM;
                    for (i = 0; i < blk_cnt; i++) begin
                        if (blk_free[i] && blk_size[i] >= rq) begin
                            if (blk_size[i] >= rq + HDR_BYTES + SPLIT_EXTRA && blk_cnt < NBLK) begin
                                for (int j = blk_cnt; j > i + 1; j--) copy_entry(j, j - 1);
                                blk_start[i+1] = blk_start[i] + HDR_BYTES + rq;
                                blk_size[i+1] = blk_size[i] - rq - HDR_BYTES;
                                blk_free[i+1] = 1;
                                blk_tag[i+1] = TAG_NEVER;
                                blk_cnt++;
                                blk_size[i] = rq;
                            end
                            blk_free[i] = 0;
                            blk_tag[i] = TAG_ALLOC;
                            used += rq + HDR_BYTES;
                            r.granted = 16'(blk_start[i] + HDR_BYTES);
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
            end else if (mode == MODE_FREE || mode == MODE_QUERY) begin
                if (is_null) begin
                    r.status = ST_ZERO;
                end else begin
                    k = -1;
                    for (i = 0; i < blk_cnt; i++) begin
                        if (blk_start[i] + HDR_BYTES == ptr) begin
                            k = i;
                            break;
                        end
                    end
                    if (k < 0) r.status = ST_INVALID;
                    else if (blk_tag[k] == TAG_FREED) r.status = ST_DOUBLE;
                    else if (blk_tag[k] != TAG_ALLOC) r.status = ST_INVALID;
                    else if (mode == MODE_QUERY) r.bytes = 16'(blk_size[k]);
                    else begin
                        blk_free[k] = 1;
                        blk_tag[k] = TAG_FREED;
                        used -= blk_size[k] + HDR_BYTES;
                        // Coalesce every adjacent pair of free blocks.
                        i = 0;
                        while (i + 1 < blk_cnt) begin
                            if (blk_free[i] && blk_free[i+1] &&
                                blk_start[i] + HDR_BYTES + blk_size[i] == blk_start[i+1]) begin
                                blk_size[i] += HDR_BYTES + blk_size[i+1];
                                for (int j = i + 1; j + 1 < blk_cnt; j++) copy_entry(j, j + 1);
                                blk_cnt--;
                            end else begin
                                i++;
                            end
                        end
                    end
                end
            end
            r.used = used;
            owed.push_back(r);
        endfunction

        task check_result(t_result got);
            t_result want;
            if (owed.size() == 0) begin
                report("unexpected result beat, status", got.status, 0);
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.granted !== want.granted) report("granted_offset", got.granted, want.granted);
            if (got.bytes !== want.bytes) report("block_bytes", got.bytes, want.bytes);
            if (got.used !== want.used) report("used_bytes", got.used, want.used);
        endtask

        // Payload offset of a random entry, allocated ones only when asked.
        function logic [15:0] pick_offset(bit live_only);
            int unsigned cand[$];
            for (int i = 0; i < blk_cnt; i++)
                if (!live_only || blk_tag[i] == TAG_ALLOC) cand.push_back(i);
            if (cand.size() == 0) return 16'($urandom);
            return 16'(blk_start[cand[$urandom_range(cand.size() - 1)]] + HDR_BYTES);
        endfunction
    endclass

    alloc_scoreboard sb = new();

    first_fit_block_allocator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_mode(i_mode), .i_request_size(i_request_size),
        .i_payload_offset(i_payload_offset), .i_null_pointer(i_null_pointer),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_status(o_status), .o_granted_offset(o_granted_offset),
        .o_block_bytes(o_block_bytes), .o_used_bytes(o_used_bytes)
    );

    always #10 i_clk = ~i_clk;

    // Cycle count and the timeout guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver stalls are redrawn every cycle.
    always @(negedge i_clk) begin
        i_out_ready <= i_rst_n && ($urandom_range(99) >= recv_idle);
    end

    // Accepted beats on both channels.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_request(i_mode, i_request_size, i_payload_offset, i_null_pointer);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result({o_status, o_granted_offset, o_block_bytes, o_used_bytes});
    end

    // Presents one request beat and holds it until it is taken. Valid stays high
    // into the next call so that back-to-back beats need no gap.
    task automatic send(input logic [1:0] mode, input logic [15:0] req, input logic [15:0] ptr,
                        input logic is_null);
        bit taken;
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_request_size <= req;
        i_payload_offset <= ptr;
        i_null_pointer <= is_null;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = i_in_valid && o_in_ready;
            @(negedge i_clk);
        end
    endtask

    task automatic random_item();
        int unsigned p;
        logic [15:0] req;
        p = $urandom_range(99);
        if (p < 45) begin
            case ($urandom_range(9))
                0:       req = 16'($urandom);
                1, 2:    req = 16'($urandom_range(2048, 1));
                default: req = 16'($urandom_range(64, 1));
            endcase
            send(MODE_ALLOC, req, 16'($urandom), 1'($urandom));
        end else if (p < 75) begin
            send(MODE_FREE, 16'($urandom), sb.pick_offset(1), 1'b0);
        end else if (p < 87) begin
            send(MODE_QUERY, 16'($urandom), sb.pick_offset(1), 1'b0);
        end else if (p < 93) begin
            send($urandom_range(1) ? MODE_FREE : MODE_QUERY, 16'($urandom),
                 sb.pick_offset(0), 1'b0);
        end else if (p < 96) begin
            send($urandom_range(1) ? MODE_FREE : MODE_QUERY, 16'($urandom),
                 16'($urandom), 1'b0);
        end else if (p < 98) begin
            send($urandom_range(1) ? MODE_FREE : MODE_QUERY, 16'($urandom),
                 sb.pick_offset(1), 1'b1);
        end else begin
            send(MODE_UNUSED, 16'($urandom), 16'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        logic [15:0] a, b;
        sb.clear();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 21;
        recv_idle = 75;

        // Directed corner cases.
        send(MODE_ALLOC, 16'd0, 16'hFFFF, 1'b1);      // zero size
        send(MODE_ALLOC, 16'hFFFF, 16'd0, 1'b0);      // rounds to the full 64 KiB, never fits
        send(MODE_ALLOC, 16'd65520, 16'd0, 1'b0);     // whole heap, no split
        send(MODE_ALLOC, 16'd8, 16'd0, 1'b0);         // out of memory
        send(MODE_QUERY, 16'd0, 16'd16, 1'b0);
        send(MODE_FREE, 16'd0, 16'd16, 1'b0);
        send(MODE_FREE, 16'd0, 16'd16, 1'b0);         // double free
        send(MODE_QUERY, 16'd0, 16'd16, 1'b0);        // query of a freed block
        send(MODE_ALLOC, 16'd1, 16'd0, 1'b1);         // null ignored on allocate
        a = 16'd16;
        send(MODE_ALLOC, 16'd100, 16'd0, 1'b0);
        b = 16'd16 + 16'd8 + 16'd16;
        send(MODE_QUERY, 16'd0, b + 16'd120, 1'b0);   // split-off remainder, never set
        send(MODE_FREE, 16'd0, a, 1'b1);              // null free
        send(MODE_QUERY, 16'd0, a, 1'b1);             // null query
        send(MODE_FREE, 16'd0, 16'd7, 1'b0);          // unknown pointer
        send(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
        send(MODE_FREE, 16'd0, b, 1'b0);
        send(MODE_FREE, 16'd0, a, 1'b0);              // merges with its neighbors
        send(MODE_QUERY, 16'd0, b, 1'b0);             // merged away
        // Fill the table so that the last grant is taken unsplit.
        for (int i = 0; i < 66; i++) send(MODE_ALLOC, 16'd8, 16'd0, 1'b0);
        for (int i = 0; i < 66; i++) send(MODE_FREE, 16'd0, 16'(16 + 24 * i), 1'b0);

        // Random traffic in three pacing phases.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 21 : (ph == 1) ? 75 : 0;
            recv_idle = (ph == 0) ? 75 : (ph == 1) ? 21 : 0;
            for (int n = 0; n < 184; n++) random_item();
        end
        i_in_valid <= 1'b0;

        while (sb.owed.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        if (errors == 0 && sb.owed.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
